// File: sv/bpv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpv_pkg: shared types and constants
// Segment record handed along the halving chain, margin settings, solver
// states and a few fixed-point helpers.
// ----------------------------------------------------------------------------
package bpv_pkg;

  localparam int MaxHalvings = 8;

  // unit parameter and one half in Q16.16
  localparam logic [16:0] TOne  = 17'd65536;
  localparam logic [41:0] XHalf = 42'd32768;

  typedef struct packed {
    logic signed [31:0] y0;
    logic signed [31:0] y1;
    logic signed [31:0] y2;
    logic signed [31:0] y3;
    logic signed [31:0] y;
    logic [16:0]        t0;
    logic [16:0]        t3;
    logic [33:0]        e;
    logic               hit;
    logic               hit_one;
  } seg_t;

  typedef struct packed {
    logic [16:0] rel;
    logic [18:0] rel3;
    logic [16:0] abs_m;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_CLASS,
    S_SCALE,
    S_CHECK,
    S_MUL_B,
    S_MUL_AC,
    S_DISC,
    S_SQRT,
    S_ROOT,
    S_DIV,
    S_MAP,
    S_FIN,
    S_OUT
  } solve_state_t;

  // floor((u + v) / 2)
  function automatic logic signed [31:0] avg_floor(input logic signed [31:0] u,
                                                   input logic signed [31:0] v);
    logic signed [32:0] s;
    s = 33'(u) + 33'(v);
    return s[32:1];
  endfunction

  function automatic logic [35:0] mag36(input logic signed [35:0] v);
    return v[35] ? 36'(-v) : 36'(v);
  endfunction

endpackage

// File: sv/bpv_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpv_cell: one de casteljau halving round
// Checks the stop conditions and either passes the segment on or keeps the
// half that holds the target. One register stage per cell.
// ----------------------------------------------------------------------------
module bpv_cell import bpv_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic in_vld,
  input  seg_t in_seg,
  output logic out_vld,
  output seg_t out_seg
);

  logic signed [32:0] d;
  logic [32:0]        mag_d;
  logic signed [32:0] diff21;
  logic signed [35:0] bend;
  logic [35:0]        mag_bend;
  logic [51:0]        lhs;
  logic [51:0]        rhs;
  logic               stop;
  logic signed [34:0] msum;
  logic signed [31:0] yc;
  logic signed [31:0] h12;
  logic signed [31:0] lo_y1;
  logic signed [31:0] lo_y2;
  logic signed [31:0] hi_y1;
  logic signed [31:0] hi_y2;
  logic [17:0]        tsum;
  logic [16:0]        tm;
  seg_t               nxt;

  always_comb begin
    d        = 33'(in_seg.y3) - 33'(in_seg.y0);
    mag_d    = d[32] ? 33'(-d) : 33'(d);
    diff21   = 33'(in_seg.y2) - 33'(in_seg.y1);
    bend     = 36'(diff21) * 36'sd3 - 36'(d);
    mag_bend = mag36(bend);
    lhs      = {mag_bend, 16'd0};
    rhs      = 52'(cfg.rel3) * 52'(mag_d);
    // span below tolerance or segment nearly linear
    stop     = (34'(mag_d) < in_seg.e) || (lhs < rhs);

    msum  = 35'(in_seg.y0) + 35'(in_seg.y1) * 35'sd3 + 35'(in_seg.y2) * 35'sd3
          + 35'(in_seg.y3);
    yc    = msum[34:3];
    h12   = avg_floor(in_seg.y1, in_seg.y2);
    lo_y1 = avg_floor(in_seg.y0, in_seg.y1);
    lo_y2 = avg_floor(lo_y1, h12);
    hi_y2 = avg_floor(in_seg.y2, in_seg.y3);
    hi_y1 = avg_floor(h12, hi_y2);
    tsum  = 18'(in_seg.t0) + 18'(in_seg.t3);
    tm    = tsum[17:1];

    nxt = in_seg;
    if (!stop) begin
      if (in_seg.y < yc) begin
        nxt.y3 = yc;
        nxt.y2 = lo_y2;
        nxt.y1 = lo_y1;
        nxt.t3 = tm;
      end else begin
        nxt.y0 = yc;
        nxt.y1 = hi_y1;
        nxt.y2 = hi_y2;
        nxt.t0 = tm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_seg <= nxt;
  end

endmodule

// File: sv/bpv_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpv_sqrt: integer square root
// Digit-by-digit root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module bpv_sqrt import bpv_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] val,
  output logic        done,
  output logic [31:0] root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitr;
  logic [63:0] trial;
  logic        take;

  always_comb begin
    trial = res + bitr;
    take  = v >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= val;
      res  <= '0;
      bitr <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (take) begin
        v   <= v - trial;
        res <= (res >> 1) + bitr;
      end else begin
        res <= res >> 1;
      end
      bitr <= bitr >> 2;
    end
  end

  assign root = res[31:0];

endmodule

// File: sv/bpv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpv_div: signed divider
// Restoring division on magnitudes, one quotient bit per cycle, quotient
// truncated toward zero.
// ----------------------------------------------------------------------------
module bpv_div import bpv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [50:0] num,
  input  logic signed [35:0] den,
  output logic               done,
  output logic signed [51:0] quo
);

  localparam int Steps = 51;
  localparam int CntW  = $clog2(Steps);

  logic            busy;
  logic [CntW-1:0] cnt;
  logic            neg;
  logic [35:0]     dm;
  logic [36:0]     rem;
  logic [50:0]     shreg;
  logic [36:0]     rs;
  logic            take;

  always_comb begin
    rs   = {rem[35:0], shreg[50]};
    take = rs >= {1'b0, dm};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(Steps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= num[50] ^ den[35];
      dm    <= den[35] ? 36'(-den) : 36'(den);
      shreg <= num[50] ? 51'(-num) : 51'(num);
      rem   <= '0;
    end else if (busy) begin
      rem   <= take ? rs - {1'b0, dm} : rs;
      shreg <= {shreg[49:0], take};
    end
  end

  assign quo = neg ? -$signed({1'b0, shreg}) : $signed({1'b0, shreg});

endmodule

// File: sv/bpv_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpv_solver: quadratic solve and parameter mapping
// Sequencer for the end-of-chain work: end matches, quadratic terms, scaling,
// discriminant, root, division and mapping back onto the kept interval.
// ----------------------------------------------------------------------------
module bpv_solver import bpv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               start,
  input  seg_t               seg_in,
  output logic               res_valid,
  input  logic               res_ready,
  output logic signed [31:0] res
);

  localparam logic signed [51:0] XLim   = 52'sd1 <<< 40;
  localparam logic signed [44:0] IntMax = 45'sd2147483647;
  localparam logic signed [44:0] IntMin = -45'sd2147483648;

  solve_state_t       state;
  solve_state_t       state_next;
  seg_t               seg;
  logic signed [35:0] a;
  logic signed [34:0] b;
  logic signed [32:0] c;
  logic               ab_neg;
  logic signed [30:0] as_r;
  logic signed [30:0] bs_r;
  logic signed [30:0] cs_r;
  logic signed [61:0] p1;
  logic signed [61:0] p2;
  logic signed [41:0] x;
  logic signed [59:0] prod;

  logic               div_start;
  logic signed [50:0] div_num;
  logic signed [35:0] div_den;
  logic               div_done;
  logic signed [51:0] div_quo;
  logic               sqrt_start;
  logic [63:0]        sqrt_val;
  logic               sqrt_done;
  logic [31:0]        sqrt_root;

  logic signed [32:0] d_pre;
  logic signed [34:0] b_pre;
  logic               lin_a;
  logic               lin_b;
  logic               sc_lin_b;
  logic [35:0]        ma;
  logic [35:0]        mb;
  logic [35:0]        mc;
  logic [35:0]        m_ab;
  logic [35:0]        m;
  logic [2:0]         k;
  logic signed [63:0] disc;
  logic signed [32:0] root_s;
  logic signed [33:0] rdiff;
  logic signed [33:0] neg_c;
  logic signed [31:0] neg_cs;
  logic signed [41:0] x_clamp;
  logic signed [44:0] r_sum;

  bpv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  bpv_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .val   (sqrt_val),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // datapath helpers
  always_comb begin
    d_pre    = 33'(seg.y1) - 33'(seg.y0);
    b_pre    = 35'(d_pre) * 35'sd3;
    ma       = mag36(a);
    mb       = mag36(36'(b));
    mc       = mag36(36'(c));
    lin_a    = ma < 36'(cfg.abs_m);
    lin_b    = (mb < 36'(cfg.abs_m)) || (b == '0);
    sc_lin_b = (mag36(36'(bs_r)) < 36'(cfg.abs_m)) || (bs_r == '0);
    m_ab     = (mb > ma) ? mb : ma;
    m        = (mc > m_ab) ? mc : m_ab;
    priority if (m[35]) k = 3'd6;
    else if (m[34])     k = 3'd5;
    else if (m[33])     k = 3'd4;
    else if (m[32])     k = 3'd3;
    else if (m[31])     k = 3'd2;
    else if (m[30])     k = 3'd1;
    else                k = 3'd0;
    disc     = 64'(p1) - (64'(p2) <<< 2);
    sqrt_val = disc[63] ? 64'd0 : 64'(disc);
    root_s   = ab_neg ? -$signed({1'b0, sqrt_root}) : $signed({1'b0, sqrt_root});
    rdiff    = 34'(root_s) - 34'(bs_r);
    neg_c    = -34'(c);
    neg_cs   = -32'(cs_r);
    if (div_quo > XLim) begin
      x_clamp = 42'(XLim);
    end else if (div_quo < -XLim) begin
      x_clamp = 42'(-XLim);
    end else begin
      x_clamp = 42'(div_quo);
    end
    r_sum = 45'(seg.t0) + 45'($signed(prod[59:16]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    res_valid  = 1'b0;
    div_num    = 51'($signed({neg_c, 16'd0}));
    div_den    = 36'(b);
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_PREP;
      end
      S_PREP: begin
        state_next = seg.hit ? S_OUT : S_CLASS;
      end
      S_CLASS: begin
        if (lin_a) begin
          if (lin_b) begin
            state_next = S_MAP;
          end else begin
            div_start  = 1'b1;
            state_next = S_DIV;
          end
        end else begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: state_next = S_CHECK;
      S_CHECK: begin
        div_num = 51'($signed({neg_cs, 16'd0}));
        div_den = 36'(bs_r);
        if (as_r == '0) begin
          if (sc_lin_b) begin
            state_next = S_MAP;
          end else begin
            div_start  = 1'b1;
            state_next = S_DIV;
          end
        end else begin
          state_next = S_MUL_B;
        end
      end
      S_MUL_B:  state_next = S_MUL_AC;
      S_MUL_AC: state_next = S_DISC;
      S_DISC: begin
        sqrt_start = 1'b1;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        if (sqrt_done) state_next = S_ROOT;
      end
      S_ROOT: begin
        div_num    = 51'($signed({rdiff, 16'd0}));
        div_den    = 36'(as_r) <<< 1;
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_done) state_next = S_MAP;
      end
      S_MAP: state_next = S_FIN;
      S_FIN: state_next = S_OUT;
      S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // operand and result registers, loaded in the state that needs them
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) seg <= seg_in;
      end
      S_PREP: begin
        c      <= 33'(seg.y0) - 33'(seg.y);
        b      <= b_pre;
        a      <= 36'(33'(seg.y3) - 33'(seg.y0)) - 36'(b_pre);
        if (seg.hit) res <= seg.hit_one ? 32'(TOne) : 32'd0;
      end
      S_CLASS: begin
        ab_neg <= (37'(a) + 37'(b)) < 0;
        if (lin_a && lin_b) x <= XHalf;
      end
      S_SCALE: begin
        as_r <= 31'(a >>> k);
        bs_r <= 31'(36'(b) >>> k);
        cs_r <= 31'(36'(c) >>> k);
      end
      S_CHECK: begin
        if (as_r == '0 && sc_lin_b) x <= XHalf;
      end
      S_MUL_B:  p1 <= 62'(bs_r) * 62'(bs_r);
      S_MUL_AC: p2 <= 62'(as_r) * 62'(cs_r);
      S_DIV: begin
        if (div_done) x <= x_clamp;
      end
      S_MAP: prod <= $signed({1'b0, 17'(seg.t3 - seg.t0)}) * 60'(x);
      S_FIN: begin
        if (r_sum > IntMax) begin
          res <= 32'(IntMax);
        end else if (r_sum < IntMin) begin
          res <= 32'(IntMin);
        end else begin
          res <= 32'(r_sum);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/bezier_parameter_from_value.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bezier_parameter_from_value: cubic bezier parameter from value
// Finds the parameter at which a one-dimensional cubic bezier reaches a
// target value: halving chain, then quadratic solve with root and divide.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------
//  in       | in_valid / in_ready      | ctrl_p0..ctrl_p3, target_value
//  out      | out_valid / out_ready    | param_out
//  cfg      | cfg_we (no wait)         | cfg_index, cfg_data
//
//  one request at a time: entry stage, halving cells (8), then the
//  solver, which passes an end match straight to the output, maps a
//  flat remainder directly, divides once for a straight line, and runs
//  the root and then the divider when the quadratic path runs; the
//  next request is taken in the cycle after the result moves into the
//  output register, even while that result waits there
//  synchronous active-high reset clears valid flags and sequencer and restores default margins
//
module bezier_parameter_from_value import bpv_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] ctrl_p0,
  input  logic signed [31:0] ctrl_p1,
  input  logic signed [31:0] ctrl_p2,
  input  logic signed [31:0] ctrl_p3,
  input  logic signed [31:0] target_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] param_out,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [16:0]        cfg_data
);

  localparam logic RegRel = 1'b0;
  localparam logic RegAbs = 1'b1;

  // margin registers
  logic [16:0] rel_tol;
  logic [16:0] abs_tol;
  cfg_t        cfg;

  // request bookkeeping
  logic        busy;
  logic        in_fire;

  // entry stage
  logic signed [32:0] d0;
  logic [32:0]        mag_d0;
  logic [49:0]        e_prod;
  logic [33:0]        e_raw;
  seg_t               seg_in;

  // halving chain
  logic               vld   [MaxHalvings+1];
  seg_t               chain [MaxHalvings+1];

  // solver handoff
  logic               res_valid;
  logic               res_ready;
  logic signed [31:0] res;

  assign cfg.rel   = rel_tol;
  assign cfg.rel3  = 19'(rel_tol) * 19'd3;
  assign cfg.abs_m = abs_tol;

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rel_tol <= 17'd655;
      abs_tol <= 17'd7;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegRel: rel_tol <= cfg_data;
        RegAbs: abs_tol <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // tolerance from the initial span, end matches flagged up front
  always_comb begin
    d0     = 33'(ctrl_p3) - 33'(ctrl_p0);
    mag_d0 = d0[32] ? 33'(-d0) : 33'(d0);
    e_prod = 50'(mag_d0) * 50'(rel_tol);
    e_raw  = e_prod[49:16];
    seg_in.y0      = ctrl_p0;
    seg_in.y1      = ctrl_p1;
    seg_in.y2      = ctrl_p2;
    seg_in.y3      = ctrl_p3;
    seg_in.y       = target_value;
    seg_in.t0      = '0;
    seg_in.t3      = TOne;
    seg_in.e       = (e_raw < 34'(abs_tol)) ? 34'(abs_tol) : e_raw;
    seg_in.hit     = (target_value == ctrl_p0) || (target_value == ctrl_p3);
    seg_in.hit_one = target_value != ctrl_p0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) chain[0] <= seg_in;
  end

  // one cell per halving round, each a pipeline stage
  for (genvar i = 0; i < MaxHalvings; i++) begin : g_cell
    bpv_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .cfg     (cfg),
      .in_vld  (vld[i]),
      .in_seg  (chain[i]),
      .out_vld (vld[i+1]),
      .out_seg (chain[i+1])
    );
  end

  bpv_solver u_solver (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .start     (vld[MaxHalvings]),
    .seg_in    (chain[MaxHalvings]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // one request in flight until its result reaches the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_fire) begin
      busy <= 1'b1;
    end else if (res_valid && res_ready) begin
      busy <= 1'b0;
    end
  end

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) param_out <= res;
  end

endmodule
